@@ hdl/mclp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared types and constants of the motor command line parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

  // Character codes used by the parser.
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;

  // Queue between the classifier and the line engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Result kinds.
  typedef enum logic [3:0] {
    KIND_PING        = 4'd0,
    KIND_STATUS      = 4'd1,
    KIND_DISABLE_ALL = 4'd2,
    KIND_ENABLE      = 4'd3,
    KIND_DISABLE     = 4'd4,
    KIND_CLEAR       = 4'd5,
    KIND_DUTY        = 4'd6,
    KIND_DIRECTION   = 4'd7,
    KIND_UNKNOWN     = 4'd8,
    KIND_OVERFLOW    = 4'd9
  } cmd_kind_e;

  // Number scanner phases.
  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } num_phase_e;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       is_lf;
    logic       is_nul;
    logic       is_space;
    logic       is_digit;
    logic       is_sign;
    logic       is_minus;
  } byte_t;

  // One result item.
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  motor;
    cmd_kind_e   kind;
  } result_t;

endpackage

@@ hdl/mclp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_front
// Classifies each received byte and drops carriage returns.
// ----------------------------------------------------------------------------
module mclp_front
  import mclp_pkg::*;
(
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       push_o,
  output byte_t      push_data_o
);

  // Character classes needed by the line engine.
  always_comb begin
    push_data_o.data     = rx_byte_i;
    push_data_o.is_lf    = (rx_byte_i == CH_LF);
    push_data_o.is_nul   = (rx_byte_i == CH_NUL);
    push_data_o.is_space = (rx_byte_i == CH_SPACE) ||
                           ((rx_byte_i >= CH_TAB) && (rx_byte_i <= CH_CR));
    push_data_o.is_digit = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
    push_data_o.is_sign  = (rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS);
    push_data_o.is_minus = (rx_byte_i == CH_MINUS);
  end

  // A carriage return is taken but never queued.
  assign push_o = rx_valid_i && (rx_byte_i != CH_CR);

endmodule

@@ hdl/mclp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_queue
// Short register queue between the classifier and the line engine.
// ----------------------------------------------------------------------------
module mclp_queue
  import mclp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  byte_t push_data_i,
  output logic  full_o,
  output logic  empty_o,
  input  logic  pop_i,
  output byte_t pop_data_o
);

  byte_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/mclp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_back
// Line engine: keeps the line state, scans the value and decodes commands
// into a registered result.
// ----------------------------------------------------------------------------
module mclp_back
  import mclp_pkg::*;
#(
  parameter int LINE_CAPACITY = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  byte_t   q_data_i,
  output logic    q_pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

  logic [7:0]  c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic        nul_q, nul_d;
  num_phase_e  phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic        valid_q, valid_d;
  result_t     res_q, res_d;
  logic        emit;
  result_t     emit_res;
  result_t     line_res;
  logic        line_nonempty;
  logic [31:0] num;
  logic [31:0] digit;
  logic        c1_motor;

  // An entry is taken whenever the result register is free or being drained.
  assign q_pop_o     = !q_empty_i && (!valid_q || res_ready_i);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  assign digit    = {28'd0, q_data_i.data[3:0]};
  assign num      = neg_q ? (32'd0 - acc_q) : acc_q;
  assign c1_motor = (c1_q >= CH_ZERO) && (c1_q <= CH_TWO);

  // Command decode of the finished line, in order of precedence.
  always_comb begin
    line_nonempty  = (c0_q != CH_NUL);
    line_res.kind  = KIND_UNKNOWN;
    line_res.motor = 2'd0;
    line_res.value = 32'd0;
    if (c0_q == CH_P && c1_q == CH_NUL) begin
      line_res.kind = KIND_PING;
    end else if (c0_q == CH_QUERY) begin
      line_res.kind = KIND_STATUS;
    end else if (c0_q == CH_D && c1_q == CH_A) begin
      line_res.kind = KIND_DISABLE_ALL;
    end else if (c1_motor && c0_q == CH_E) begin
      line_res.kind  = KIND_ENABLE;
      line_res.motor = c1_q[1:0];
    end else if (c1_motor && c0_q == CH_D) begin
      line_res.kind  = KIND_DISABLE;
      line_res.motor = c1_q[1:0];
    end else if (c1_motor && c0_q == CH_C) begin
      line_res.kind  = KIND_CLEAR;
      line_res.motor = c1_q[1:0];
    end else if (c1_motor && c2_q == CH_COMMA && c0_q == CH_S) begin
      line_res.kind  = KIND_DUTY;
      line_res.motor = c1_q[1:0];
      line_res.value = num;
    end else if (c1_motor && c2_q == CH_COMMA && c0_q == CH_R) begin
      line_res.kind  = KIND_DIRECTION;
      line_res.motor = c1_q[1:0];
      line_res.value = {31'd0, (num != 32'd0)};
    end
  end

  // Per-byte line state update.
  always_comb begin
    c0_d     = c0_q;
    c1_d     = c1_q;
    c2_d     = c2_q;
    len_d    = len_q;
    nul_d    = nul_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    emit     = 1'b0;
    emit_res = line_res;
    if (q_pop_o) begin
      if (q_data_i.is_lf || (len_q >= LEN_LIMIT)) begin
        // End of line or overflow: report a non-empty line or the overflow, and start a fresh line.
        if (q_data_i.is_lf) begin
          emit = line_nonempty;
        end else begin
          emit           = 1'b1;
          emit_res.kind  = KIND_OVERFLOW;
          emit_res.motor = 2'd0;
          emit_res.value = 32'd0;
        end
        c0_d    = CH_NUL;
        c1_d    = CH_NUL;
        c2_d    = CH_NUL;
        len_d   = '0;
        nul_d   = 1'b0;
        phase_d = PH_SKIP;
        neg_d   = 1'b0;
        acc_d   = 32'd0;
      end else begin
        if (!nul_q) begin
          if (q_data_i.is_nul) begin
            nul_d = 1'b1;
          end else if (len_q == LEN_W'(0)) begin
            c0_d = q_data_i.data;
          end else if (len_q == LEN_W'(1)) begin
            c1_d = q_data_i.data;
          end else if (len_q == LEN_W'(2)) begin
            c2_d = q_data_i.data;
          end else begin
            // The value scanner behaves like atoi.
            unique case (phase_q)
              PH_SKIP: begin
                if (q_data_i.is_space) begin
                  phase_d = PH_SKIP;
                end else if (q_data_i.is_sign) begin
                  neg_d   = q_data_i.is_minus;
                  phase_d = PH_DIGITS;
                end else if (q_data_i.is_digit) begin
                  acc_d   = digit;
                  phase_d = PH_DIGITS;
                end else begin
                  phase_d = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (q_data_i.is_digit) begin
                  acc_d = (acc_q << 3) + (acc_q << 1) + digit;
                end else begin
                  phase_d = PH_DONE;
                end
              end
              PH_DONE: begin
                phase_d = PH_DONE;
              end
              default: begin
                phase_d = PH_DONE;
              end
            endcase
          end
        end
        len_d = len_q + 1'b1;
      end
    end
  end

  // Result register: loads a new result or empties once taken.
  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (valid_q && res_ready_i) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      valid_d = 1'b1;
      res_d   = emit_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q    <= CH_NUL;
      c1_q    <= CH_NUL;
      c2_q    <= CH_NUL;
      len_q   <= '0;
      nul_q   <= 1'b0;
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      acc_q   <= 32'd0;
      valid_q <= 1'b0;
    end else begin
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      len_q   <= len_d;
      nul_q   <= nul_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      valid_q <= valid_d;
    end
  end

  // The result payload is qualified by its valid flag.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

@@ hdl/motor_command_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_command_line_parser
// Turns received serial bytes into decoded motor command results.
//
//   Channel   Dir  Width  Content
//   s_axis    in   8      rx_byte
//   m_axis    out  40     cmd_kind, motor, value
//
// One byte is accepted per clock cycle in steady state; the line engine
// handles each byte as it pops it, and a result appears once the line feed
// that completes it has passed the queue and the result register. The rate
// is set by the line engine behind a two-entry queue. Reset clears the
// line state and the queue at once, with no clearing pass. When the result
// is not taken the engine stops, the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module motor_command_line_parser
  import mclp_pkg::*;
#(
  parameter int LINE_CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [3:0] cmd_kind, [5:4] motor, [37:6] value
);

  logic    push;
  byte_t   push_data;
  logic    q_full, q_empty, q_pop;
  byte_t   q_data;
  result_t res;

  assign s_axis_tready = !q_full;

  // Classifier.
  mclp_front u_front (
    .rx_byte_i   (s_axis_tdata),
    .rx_valid_i  (s_axis_tvalid && s_axis_tready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue between the two sides.
  mclp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  // Line engine and result register.
  mclp_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.value, res.motor, res.kind};

endmodule

@@ hdl/mclp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_checker
// Port-level checks on the result stream of the parser.
// ----------------------------------------------------------------------------
module mclp_checker
  import mclp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [3:0]  kind;
  logic [1:0]  motor;
  logic [31:0] value;
  logic        per_motor;

  assign kind      = m_axis_tdata[3:0];
  assign motor     = m_axis_tdata[5:4];
  assign value     = m_axis_tdata[37:6];
  assign per_motor = (kind == KIND_ENABLE) || (kind == KIND_DISABLE) ||
                     (kind == KIND_CLEAR) || (kind == KIND_DUTY) ||
                     (kind == KIND_DIRECTION);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Kinds above overflow are never produced; padding stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (kind <= KIND_OVERFLOW) && (m_axis_tdata[39:38] == 2'b00))
    else $error("bad result kind or padding");

  // Only per-motor commands carry a motor index, and it is at most two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (per_motor || motor == 2'd0) && (motor != 2'd3))
    else $error("bad motor index");

  // Only duty and direction carry a value; direction is a single bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((kind == KIND_DUTY) || (value[31:1] == 31'd0)) &&
                      ((kind == KIND_DUTY) || (kind == KIND_DIRECTION) ||
                       (value == 32'd0)))
    else $error("value on a command that carries none");

endmodule

bind motor_command_line_parser mclp_checker u_mclp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
